FILE: src/assc_pkg.sv
// assc_pkg: types and constants shared by the step size controller modules
// no dependencies
package assc_pkg;

  localparam int STEP_W   = 24;
  localparam int TICK_W   = 17;
  localparam int SUB_W    = 16;
  localparam int PHASE_W  = 16;
  localparam int SAMPLE_W = 24;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam logic [TICK_W-1:0]   TPS_RESET   = TICK_W'(128);
  localparam logic [TICK_W-1:0]   TPS_MAX     = TICK_W'(65536);
  localparam logic [PHASE_W-1:0]  SPS_RESET   = PHASE_W'(1);
  localparam logic [STEP_W-1:0]   TOTAL_RESET = STEP_W'(10);
  localparam logic [TICK_W-1:0]   SIZE_RESET  = TICK_W'(128);

  typedef enum logic [1:0] {
    REG_TPS   = 2'd0,
    REG_SPS   = 2'd1,
    REG_TOTAL = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_ACCEPT      = 3'd0,
    ST_ACCEPT_LAST = 3'd1,
    ST_FAIL_FROZEN = 3'd2,
    ST_FAIL_HALVE  = 3'd3,
    ST_FAIL_MIN    = 3'd4,
    ST_FROZEN      = 3'd5,
    ST_IDLE        = 3'd6
  } status_t;

  typedef struct packed {
    logic [TICK_W-1:0]  tps;
    logic [PHASE_W-1:0] sps;
    logic [STEP_W-1:0]  total;
  } cfg_t;

  typedef struct packed {
    status_t             status;
    logic [STEP_W-1:0]   step_before;
    logic [SUB_W-1:0]    subtick_before;
    logic [TICK_W-1:0]   size_tried;
    logic [TICK_W-1:0]   size_next;
    logic [SAMPLE_W-1:0] sample_index;
    logic                sample_start;
    logic                sample_end;
    logic                restore_backup;
    logic                done_res;
  } result_t;

endpackage

FILE: src/adaptive_step_size_controller.sv
// adaptive_step_size_controller: top level with input and result registers
// depends on assc_pkg, assc_cfg and assc_core
//
// usage
//   input channel: in_valid/in_stall carry one attempt word (attempt_ok,
//   freeze_request). output channel: out_valid/out_stall carry one result
//   word per input word (status, time before the attempt, sizes, sample
//   flags, restore_backup, done_res).
//   registers ticks_per_step, steps_per_sample and total_steps sit on the
//   apb port at byte addresses 0, 4 and 8; write them only while no word
//   is in flight.
//   path: an accepted word loads the input register, then the result
//   register once that one can advance (it is not both full and stalled).
//   throughput: one word per cycle while the result is not stalled; the
//   state update uses adds, compares and a three-way min on registers.
//   reset: synchronous; clears both valid bits, restores register defaults
//   and returns time to step 0 with sub-step size 128.
//   stall: a stalled result holds; the input register keeps its word and
//   raises in_stall only while the result register is full and stalled.
module adaptive_step_size_controller import assc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                attempt_ok,
  input  logic                freeze_request,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          status,
  output logic [STEP_W-1:0]   step_before,
  output logic [SUB_W-1:0]    subtick_before,
  output logic [TICK_W-1:0]   size_tried,
  output logic [TICK_W-1:0]   size_next,
  output logic [SAMPLE_W-1:0] sample_index,
  output logic                sample_start,
  output logic                sample_end,
  output logic                restore_backup,
  output logic                done_res
);

  cfg_t    cfg;
  result_t core_res;
  result_t res;
  logic    in_v;
  logic    in_ok;
  logic    in_frz;
  logic    out_v;
  logic    advance;
  logic    fire;

  assc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assc_core u_core (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .fire           (fire),
    .attempt_ok     (in_ok),
    .freeze_request (in_frz),
    .res            (core_res)
  );

  assign advance  = ~out_v | ~out_stall;
  assign fire     = in_v & advance;
  assign in_stall = in_v & ~advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v  <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_v <= in_valid;
      end
      if (advance) begin
        out_v <= in_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_ok  <= attempt_ok;
      in_frz <= freeze_request;
    end
    if (fire) begin
      res <= core_res;
    end
  end

  assign out_valid      = out_v;
  assign status         = res.status;
  assign step_before    = res.step_before;
  assign subtick_before = res.subtick_before;
  assign size_tried     = res.size_tried;
  assign size_next      = res.size_next;
  assign sample_index   = res.sample_index;
  assign sample_start   = res.sample_start;
  assign sample_end     = res.sample_end;
  assign restore_backup = res.restore_backup;
  assign done_res       = res.done_res;

endmodule

FILE: src/assc_cfg.sv
// assc_cfg: apb register file for the step size controller
// depends on assc_pkg
module assc_cfg import assc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tps   <= TPS_RESET;
      cfg.sps   <= SPS_RESET;
      cfg.total <= TOTAL_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_TPS:   cfg.tps   <= pwdata[TICK_W-1:0];
        REG_SPS:   cfg.sps   <= pwdata[PHASE_W-1:0];
        REG_TOTAL: cfg.total <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TPS:   prdata = DATA_W'(cfg.tps);
      REG_SPS:   prdata = DATA_W'(cfg.sps);
      REG_TOTAL: prdata = DATA_W'(cfg.total);
      default:   prdata = '0;
    endcase
  end

endmodule

FILE: src/assc_core.sv
// assc_core: time and step size state with the per-word classification logic
// depends on assc_pkg
module assc_core import assc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    fire,
  input  logic    attempt_ok,
  input  logic    freeze_request,
  output result_t res
);

  logic [STEP_W-1:0]   step_count, step_count_next;
  logic [SUB_W-1:0]    subtick, subtick_next;
  logic [TICK_W-1:0]   step_size, step_size_next;
  logic [TICK_W-1:0]   last_tried, last_tried_next;
  logic                last_flag, last_flag_next;
  logic                frozen, frozen_next;
  logic [PHASE_W-1:0]  sample_phase, sample_phase_next;
  logic [SAMPLE_W-1:0] sample_count, sample_count_next;

  logic [TICK_W-1:0]   tps_eff;
  logic [PHASE_W-1:0]  sps_eff;
  logic                idle;
  logic [TICK_W:0]     end_sum;
  logic                full_end;
  logic [PHASE_W:0]    phase_inc;
  logic                period_end;
  logic                frozen_eff;
  status_t             status;
  logic                advance;
  logic [TICK_W:0]     extend;
  logic [TICK_W:0]     remain;
  logic [TICK_W:0]     min_a;
  logic [TICK_W:0]     min_b;

  always_comb begin
    if (cfg.tps == '0) begin
      tps_eff = TICK_W'(1);
    end else if (cfg.tps > TPS_MAX) begin
      tps_eff = TPS_MAX;
    end else begin
      tps_eff = cfg.tps;
    end
    sps_eff    = (cfg.sps == '0) ? PHASE_W'(1) : cfg.sps;
    idle       = step_count >= cfg.total;
    end_sum    = (TICK_W+1)'(subtick) + (TICK_W+1)'(step_size);
    full_end   = end_sum >= (TICK_W+1)'(tps_eff);
    phase_inc  = (PHASE_W+1)'(sample_phase) + (PHASE_W+1)'(1);
    period_end = full_end && (phase_inc >= (PHASE_W+1)'(sps_eff));
    frozen_eff = frozen | freeze_request;

    if (frozen_eff) begin
      status = ST_FROZEN;
    end else if (attempt_ok) begin
      status = last_flag ? ST_ACCEPT_LAST : ST_ACCEPT;
    end else if (last_flag) begin
      status = ST_FAIL_FROZEN;
    end else if (step_size > TICK_W'(1)) begin
      status = ST_FAIL_HALVE;
    end else begin
      status = ST_FAIL_MIN;
    end
    advance = (status == ST_ACCEPT) || (status == ST_ACCEPT_LAST) ||
              (status == ST_FAIL_FROZEN) || (status == ST_FROZEN);

    step_count_next   = step_count;
    subtick_next      = subtick;
    step_size_next    = step_size;
    last_tried_next   = last_tried;
    last_flag_next    = last_flag;
    frozen_next       = frozen;
    sample_phase_next = sample_phase;
    sample_count_next = sample_count;
    extend            = '0;
    remain            = '0;
    min_a             = '0;
    min_b             = '0;

    if (!idle) begin
      frozen_next     = frozen_eff | (status == ST_FAIL_FROZEN);
      last_tried_next = step_size;
      if (advance) begin
        last_flag_next = 1'b0;
        if (full_end) begin
          step_count_next = step_count + STEP_W'(1);
          subtick_next    = '0;
          if (period_end) begin
            sample_phase_next = '0;
            sample_count_next = sample_count + SAMPLE_W'(1);
          end else begin
            sample_phase_next = phase_inc[PHASE_W-1:0];
          end
        end else begin
          subtick_next = end_sum[SUB_W-1:0];
        end
        extend = full_end ? (TICK_W+1)'(last_tried) : {step_size, 1'b0};
        remain = (TICK_W+1)'(tps_eff) - (TICK_W+1)'(subtick_next);
        min_a  = (extend < (TICK_W+1)'(tps_eff)) ? extend : (TICK_W+1)'(tps_eff);
        min_b  = (remain < min_a) ? remain : min_a;
        step_size_next = (min_b == '0) ? TICK_W'(1) : min_b[TICK_W-1:0];
      end else begin
        last_flag_next = (step_size == TICK_W'(1));
        if (step_size > TICK_W'(1)) begin
          step_size_next = step_size >> 1;
        end else begin
          step_size_next = TICK_W'(1);
        end
      end
    end

    res.status         = idle ? ST_IDLE : status;
    res.step_before    = step_count;
    res.subtick_before = subtick;
    res.size_tried     = step_size;
    res.size_next      = step_size_next;
    res.sample_index   = sample_count_next;
    res.sample_start   = !idle && (subtick == '0) && (sample_phase == '0);
    res.sample_end     = !idle && period_end;
    res.restore_backup = !idle && !advance;
    res.done_res       = step_count_next >= cfg.total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count   <= '0;
      subtick      <= '0;
      step_size    <= SIZE_RESET;
      last_tried   <= SIZE_RESET;
      last_flag    <= 1'b0;
      frozen       <= 1'b0;
      sample_phase <= '0;
      sample_count <= '0;
    end else if (fire) begin
      step_count   <= step_count_next;
      subtick      <= subtick_next;
      step_size    <= step_size_next;
      last_tried   <= last_tried_next;
      last_flag    <= last_flag_next;
      frozen       <= frozen_next;
      sample_phase <= sample_phase_next;
      sample_count <= sample_count_next;
    end
  end

endmodule
